### design/ptd_pkg.sv
`timescale 1ns / 1ps

package ptd_pkg;

  localparam int CHANNELS         = 4;
  localparam int STEPS_PER_OCTAVE = 768;
  localparam int QUO_BITS         = 24;
  localparam int A4_KFS           = 4416;
  localparam int DIV_MAX          = 1023;
  localparam int SERIES_TERMS     = 20;
  localparam longint unsigned LN2_Q31 = 64'd1488522236;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 26;
  localparam int CLK_W      = 26;
  localparam int REF_W      = 19;
  localparam int MANT_W     = 25;
  localparam int CLK1000_W  = 36;
  localparam int NUM_W      = CLK1000_W + MANT_W;
  localparam int X_W        = NUM_W + 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MASTER_CLOCK = 2'd0,
    CFG_REF_PITCH    = 2'd1
  } cfg_idx_e;

  typedef logic [MANT_W-1:0] mant_tab_t [STEPS_PER_OCTAVE];

  typedef struct packed {
    logic                v;
    logic [2:0]          ch;
    logic                ok;
    logic                sat;
    logic [REF_W-1:0]    rem;
    logic [QUO_BITS-1:0] dvd;
    logic [QUO_BITS-1:0] quo;
  } ptd_div_t;

  typedef struct packed {
    logic [2:0] ch;
    logic       valid_res;
    logic [9:0] divider;
    logic [1:0] octave;
  } ptd_res_t;

  // restoring division of a dividend below 2^32
  function automatic longint unsigned div_small(longint unsigned dvd, longint unsigned dvs);
    longint unsigned quo;
    longint unsigned rem;
    quo = 64'd0;
    rem = 64'd0;
    for (int i = 31; i >= 0; i--) begin
      rem = {rem[62:0], dvd[i]};
      if (rem >= dvs) begin
        rem -= dvs;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic mant_tab_t gen_mant_tab();
    mant_tab_t       tab;
    longint unsigned x;
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned t;
    for (int k = 0; k < STEPS_PER_OCTAVE; k++) begin
      x   = (longint'(k) * LN2_Q31 + 64'd384) / STEPS_PER_OCTAVE;
      pos = 64'd1 << 31;
      neg = 64'd0;
      t   = 64'd1 << 31;
      for (int n = 1; n <= SERIES_TERMS; n++) begin
        t = div_small((t * x) >> 31, longint'(n));
        if (n % 2 == 1) neg += t;
        else pos += t;
      end
      tab[k] = MANT_W'(((pos - neg) + 64'd64) >> 7);
    end
    return tab;
  endfunction

  localparam mant_tab_t MANT_TAB = gen_mant_tab();

endpackage

### design/pitch_to_divider_octave_core.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake                 | Payload
// in      | in        | in_valid_i / in_ready_o   | channel, note, fine_tune, pitch_offset, lfo
// out     | out       | out_valid_o / out_ready_i | channel_out, valid_res, divider, octave
// cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
// One request per cycle while in_ready_o is high; the path holds five front stages
// (sum, octave split, mantissa ROM, multiply, shift) and 24 divider cells, one
// quotient bit each, plus the output register.
// Reset clears all stage valid bits and loads the default clock and reference pitch.
// A stalled output holds one extra result in a skid stage; in_ready_o drops only
// once that stage is full, and the whole chain holds until it drains.

module pitch_to_divider_octave_core import ptd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            channel_i,
  input  logic [7:0]            note_i,
  input  logic signed [12:0]    fine_tune_i,
  input  logic signed [15:0]    pitch_offset_i,
  input  logic                  lfo_active_i,
  input  logic signed [15:0]    lfo_value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            channel_out_o,
  output logic                  valid_res_o,
  output logic [9:0]            divider_o,
  output logic [1:0]            octave_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [CLK_W-1:0]     master_q;
  logic [REF_W-1:0]     ref_q;
  logic [CLK1000_W-1:0] clk1000_q;
  logic                 en;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_q <= CLK_W'(4000000);
      ref_q    <= REF_W'(440000);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MASTER_CLOCK: master_q <= cfg_data_i[CLK_W-1:0];
        CFG_REF_PITCH:    ref_q    <= cfg_data_i[REF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    clk1000_q <= CLK1000_W'(master_q) * CLK1000_W'(1000);
  end

  // stage A: pitch sum
  logic               a_v_q, a_ok_q;
  logic [2:0]         a_ch_q;
  logic signed [18:0] a_d_q, a_d_d;
  logic               a_ok_d;

  always_comb begin
    a_d_d = $signed({5'b0, note_i, 6'b0}) + 19'(fine_tune_i) + 19'(pitch_offset_i)
          + (lfo_active_i ? 19'(lfo_value_i) : 19'sd0) - 19'(A4_KFS);
    a_ok_d = ({1'b0, channel_i} < 4'(CHANNELS)) && !note_i[7] && (ref_q != '0);
  end

  // stage B: octave and step
  logic              b_v_q, b_ok_q;
  logic [2:0]        b_ch_q;
  logic [9:0]        b_k_q, b_k_d;
  logic signed [9:0] b_s_q, b_s_d;
  logic [17:0]       u;
  logic [19:0]       prod;
  logic [8:0]        pq;
  logic [17:0]       krem;

  always_comb begin
    u     = 18'(a_d_q + 19'sd98304);
    prod  = 20'(u[17:8]) * 20'd683;
    pq    = prod[19:11];
    krem  = u - ({pq, 9'b0} + {1'b0, pq, 8'b0});
    b_k_d = krem[9:0];
    b_s_d = 10'sd112 - $signed({1'b0, pq});
  end

  // stage C: mantissa ROM
  logic              c_v_q, c_ok_q;
  logic [2:0]        c_ch_q;
  logic [MANT_W-1:0] c_mant_q;
  logic signed [9:0] c_s_q;

  // stage D: numerator
  logic              d_v_q, d_ok_q;
  logic [2:0]        d_ch_q;
  logic [NUM_W-1:0]  d_num_q;
  logic signed [9:0] d_s_q;

  // stage E: scaled dividend
  logic              e_v_q, e_ok_q, e_sat_q, e_sat_d;
  logic [2:0]        e_ch_q;
  logic [X_W-1:0]    e_x_q, e_x_d;
  logic [9:0]        neg_s;

  always_comb begin
    neg_s   = 10'(-d_s_q);
    e_sat_d = 1'b0;
    e_x_d   = '0;
    if (d_s_q > 10'sd10) begin
      e_sat_d = 1'b1;
    end else if (d_s_q >= 10'sd0) begin
      e_x_d = X_W'(d_num_q) << d_s_q[3:0];
    end else if (neg_s < 10'd64) begin
      e_x_d = X_W'(d_num_q >> neg_s[5:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= in_valid_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
      e_v_q <= d_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_ch_q   <= channel_i;
      a_ok_q   <= a_ok_d;
      a_d_q    <= a_d_d;
      b_ch_q   <= a_ch_q;
      b_ok_q   <= a_ok_q;
      b_k_q    <= b_k_d;
      b_s_q    <= b_s_d;
      c_ch_q   <= b_ch_q;
      c_ok_q   <= b_ok_q;
      c_mant_q <= MANT_TAB[b_k_q];
      c_s_q    <= b_s_q;
      d_ch_q   <= c_ch_q;
      d_ok_q   <= c_ok_q;
      d_num_q  <= NUM_W'(clk1000_q) * NUM_W'(c_mant_q);
      d_s_q    <= c_s_q;
      e_ch_q   <= d_ch_q;
      e_ok_q   <= d_ok_q;
      e_x_q    <= e_x_d;
      e_sat_q  <= e_sat_d;
    end
  end

  // divider cell chain
  ptd_div_t chain [QUO_BITS+1];

  always_comb begin
    chain[0].v   = e_v_q;
    chain[0].ch  = e_ch_q;
    chain[0].ok  = e_ok_q;
    chain[0].sat = e_sat_q || (e_x_q[X_W-1:REF_W+QUO_BITS] != '0)
                 || (e_x_q[REF_W+QUO_BITS-1:0] >= {ref_q, {QUO_BITS{1'b0}}});
    chain[0].rem = e_x_q[REF_W+QUO_BITS-1:QUO_BITS];
    chain[0].dvd = e_x_q[QUO_BITS-1:0];
    chain[0].quo = '0;
  end

  for (genvar i = 0; i < QUO_BITS; i++) begin : g_cell
    ptd_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ref_i  (ref_q),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  // octave pick and rounding
  ptd_div_t           last;
  ptd_res_t           res, res_out;
  logic [QUO_BITS:0]  dq;
  logic [QUO_BITS:0]  rounded;
  logic [QUO_BITS:0]  dv_full;
  logic [1:0]         sh;

  always_comb begin
    last = chain[QUO_BITS];
    dq   = last.sat ? (QUO_BITS+1)'(1) << QUO_BITS : {1'b0, last.quo};
    if (dq <= (QUO_BITS+1)'(DIV_MAX) << 8)       sh = 2'd0;
    else if (dq <= (QUO_BITS+1)'(DIV_MAX) << 9)  sh = 2'd1;
    else if (dq <= (QUO_BITS+1)'(DIV_MAX) << 10) sh = 2'd2;
    else                                         sh = 2'd3;
    rounded = dq + ((QUO_BITS+1)'(1) << (5'd7 + 5'(sh)));
    dv_full = rounded >> (5'd8 + 5'(sh));
    res.ch        = last.ch;
    res.valid_res = last.ok;
    res.octave    = last.ok ? 2'd3 - sh : 2'd0;
    if (!last.ok)                                res.divider = 10'd0;
    else if (dv_full == '0)                      res.divider = 10'd1;
    else if (dv_full > (QUO_BITS+1)'(DIV_MAX))   res.divider = 10'(DIV_MAX);
    else                                         res.divider = dv_full[9:0];
  end

  ptd_out_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (last.v && en),
    .res_i       (res),
    .space_o     (en),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign in_ready_o    = en;
  assign channel_out_o = res_out.ch;
  assign valid_res_o   = res_out.valid_res;
  assign divider_o     = res_out.divider;
  assign octave_o      = res_out.octave;

  a_stall_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  a_valid_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && valid_res_o |-> divider_o != 10'd0)
    else $error("valid result with zero divider");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> divider_o == 10'd0 && octave_o == 2'd0)
    else $error("invalid result with nonzero fields");

endmodule

### design/ptd_div_cell.sv
`timescale 1ns / 1ps

module ptd_div_cell import ptd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [REF_W-1:0] ref_i,
  input  ptd_div_t         cell_i,
  output ptd_div_t         cell_o
);

  ptd_div_t       cell_q, cell_d;
  logic [REF_W:0] trial;
  logic [REF_W:0] diff;
  logic           ge;

  always_comb begin
    trial       = {cell_i.rem, cell_i.dvd[QUO_BITS-1]};
    ge          = trial >= {1'b0, ref_i};
    diff        = trial - {1'b0, ref_i};
    cell_d      = cell_i;
    cell_d.rem  = ge ? diff[REF_W-1:0] : trial[REF_W-1:0];
    cell_d.dvd  = {cell_i.dvd[QUO_BITS-2:0], 1'b0};
    cell_d.quo  = {cell_i.quo[QUO_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

### design/ptd_out_skid.sv
`timescale 1ns / 1ps

module ptd_out_skid import ptd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  ptd_res_t res_i,
  output logic     space_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ptd_res_t res_o
);

  logic     main_v_q, main_v_d, skid_v_q, skid_v_d;
  ptd_res_t main_q, main_d, skid_q, skid_d;
  logic     pop;

  assign pop = main_v_q && out_ready_i;

  always_comb begin
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    main_d   = main_q;
    skid_d   = skid_q;
    if (pop) begin
      if (skid_v_q) begin
        main_d   = skid_q;
        skid_v_d = 1'b0;
      end else begin
        main_v_d = push_i;
        main_d   = res_i;
      end
    end else if (push_i) begin
      if (!main_v_q) begin
        main_v_d = 1'b1;
        main_d   = res_i;
      end else begin
        skid_v_d = 1'b1;
        skid_d   = res_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign space_o     = !skid_v_q;
  assign out_valid_o = main_v_q;
  assign res_o       = main_q;

endmodule

### tb/sv/tb_pitch_to_divider_octave_core.sv
`timescale 1ns / 1ps

module tb_pitch_to_divider_octave_core;
  import ptd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 3000;

  typedef struct {
    logic [2:0]          ch;
    logic [7:0]          note;
    logic signed [12:0]  fine;
    logic signed [15:0]  bend;
    logic                lfo_on;
    logic signed [15:0]  lfo;
  } pitch_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [2:0] channel_i = '0;
  logic [7:0] note_i = '0;
  logic signed [12:0] fine_tune_i = '0;
  logic signed [15:0] pitch_offset_i = '0;
  logic lfo_active_i = 1'b0;
  logic signed [15:0] lfo_value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [2:0] channel_out_o;
  logic valid_res_o;
  logic [9:0] divider_o;
  logic [1:0] octave_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  pitch_to_divider_octave_core DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  ptd_res_t        divider_q[$];
  longint unsigned pow2_q24 [STEPS_PER_OCTAVE];
  longint unsigned clock_hz = 4000000;
  longint unsigned a4_mhz   = 440000;
  int fails = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  function automatic longint unsigned exp_neg_q24(int k);
    longint unsigned x, sum_p, sum_n, term;
    x = (longint'(k) * 64'd1488522236 + 64'd384) / 64'd768;
    sum_p = 64'd1 << 31;
    sum_n = 0;
    term = 64'd1 << 31;
    for (int n = 1; n <= 20; n++) begin
      term = ((term * x) >> 31) / longint'(n);
      if (n % 2) sum_n += term;
      else sum_p += term;
    end
    return ((sum_p - sum_n) + 64'd64) >> 7;
  endfunction

  function automatic ptd_res_t predict_divider(pitch_req_t r);
    ptd_res_t res;
    longint d, oct, k, s;
    longint unsigned num, qt, rm, dq, dv;
    int sh;
    res = '0;
    res.ch = r.ch;
    if (r.ch >= CHANNELS || r.note >= 128 || a4_mhz == 0) return res;
    d = longint'(r.note) * 64 + r.fine + r.bend + (r.lfo_on ? longint'(r.lfo) : 0) - 4416;
    oct = d / 768;
    k = d % 768;
    if (k < 0) begin
      k += 768;
      oct -= 1;
    end
    num = clock_hz * 1000 * pow2_q24[k];
    s = -16 - oct;
    qt = num / a4_mhz;
    rm = num % a4_mhz;
    if (s >= 0) begin
      if (s > 10 || qt >= (64'd1 << 24)) dq = 64'd1 << 24;
      else dq = (qt << s) + ((rm << s) / a4_mhz);
    end else begin
      dq = (-s >= 64) ? 0 : (qt >> (-s));
    end
    if (dq > (64'd1 << 24)) dq = 64'd1 << 24;
    sh = 0;
    while (sh < 3 && dq > (64'd1023 << (8 + sh))) sh++;
    dv = (dq + (64'd1 << (7 + sh))) >> (8 + sh);
    if (dv < 1) dv = 1;
    if (dv > 1023) dv = 1023;
    res.valid_res = 1'b1;
    res.divider = dv[9:0];
    res.octave = 2'(3 - sh);
    return res;
  endfunction

  task automatic send_pitch(pitch_req_t r);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid_i = 1'b1;
    channel_i = r.ch;
    note_i = r.note;
    fine_tune_i = r.fine;
    pitch_offset_i = r.bend;
    lfo_active_i = r.lfo_on;
    lfo_value_i = r.lfo;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    divider_q.push_back(predict_divider(r));
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait (divider_q.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_MASTER_CLOCK) clock_hz = val;
    else if (idx == CFG_REF_PITCH) a4_mhz = val[REF_W-1:0];
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic pitch_req_t make_req(int ch, int note, int fine, int bend, int on, int lfo);
    pitch_req_t r;
    r.ch = 3'(ch);
    r.note = 8'(note);
    r.fine = 13'(fine);
    r.bend = 16'(bend);
    r.lfo_on = 1'(on);
    r.lfo = 16'(lfo);
    return r;
  endfunction

  function automatic pitch_req_t rand_req();
    pitch_req_t r;
    r.ch = ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(CHANNELS - 1));
    r.note = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(127));
    if ($urandom_range(3) == 0) begin
      r.fine = 13'($urandom);
      r.bend = 16'($urandom);
      r.lfo = 16'($urandom);
    end else begin
      r.fine = 13'($urandom_range(0, 256)) - 13'sd128;
      r.bend = 16'($urandom_range(0, 1536)) - 16'sd768;
      r.lfo = 16'($urandom_range(0, 256)) - 16'sd128;
    end
    r.lfo_on = 1'($urandom);
    return r;
  endfunction

  task automatic test_directed();
    send_pitch(make_req(0, 69, 0, 0, 0, 0));
    send_pitch(make_req(1, 0, 0, 0, 0, 0));
    send_pitch(make_req(2, 127, 0, 0, 0, 0));
    send_pitch(make_req(3, 127, 4095, 32767, 1, 32767));
    send_pitch(make_req(0, 0, -4096, -32768, 1, -32768));
    send_pitch(make_req(1, 60, -4096, 0, 0, 0));
    send_pitch(make_req(2, 60, 4095, 0, 1, 0));
    send_pitch(make_req(3, 69, 0, 32767, 0, -32768));
    send_pitch(make_req(0, 69, 0, -32768, 0, 32767));
    send_pitch(make_req(1, 128, 0, 0, 0, 0));
    send_pitch(make_req(2, 255, -1, -1, 1, -1));
    send_pitch(make_req(4, 69, 0, 0, 0, 0));
    send_pitch(make_req(7, 127, 4095, 32767, 1, 32767));
    send_pitch(make_req(3, 45, 100, -200, 1, 300));
    send_pitch(make_req(0, 93, 0, 0, 1, -767));
    send_pitch(make_req(1, 20, 0, 0, 0, 0));
  endtask

  task automatic test_config_cases();
    write_reg(CFG_REF_PITCH, 26'd0);
    send_pitch(make_req(0, 69, 0, 0, 0, 0));
    send_pitch(make_req(5, 40, 0, 0, 1, 5));
    write_reg(CFG_REF_PITCH, 26'd440000);
    write_reg(CFG_MASTER_CLOCK, 26'd0);
    send_pitch(make_req(1, 69, 0, 0, 0, 0));
    send_pitch(make_req(2, 0, -4096, -32768, 1, -32768));
    write_reg(CFG_SPARE_A, 26'h3ffffff);
    write_reg(CFG_SPARE_B, 26'h1555555);
    send_pitch(make_req(3, 30, 0, 0, 0, 0));
    write_reg(CFG_MASTER_CLOCK, 26'd4000000);
  endtask

  task automatic test_random(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) send_pitch(rand_req());
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 400;
    repeat (80) send_pitch(rand_req());
  endtask

  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = !($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    ptd_res_t want;
    if (out_valid_o && out_ready_i) begin
      if (divider_q.size() == 0) begin
        $error("unexpected result: channel_out %0d", channel_out_o);
        fails++;
      end else begin
        want = divider_q.pop_front();
        if (channel_out_o !== want.ch) begin
          $error("channel_out exp %0d got %0d", want.ch, channel_out_o);
          fails++;
        end
        if (valid_res_o !== want.valid_res) begin
          $error("valid_res exp %0d got %0d", want.valid_res, valid_res_o);
          fails++;
        end
        if (divider_o !== want.divider) begin
          $error("divider exp %0d got %0d", want.divider, divider_o);
          fails++;
        end
        if (octave_o !== want.octave) begin
          $error("octave exp %0d got %0d", want.octave, octave_o);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || (divider_q.size() == 0 && !in_valid_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_pitch_to_divider_octave_core NOT OK");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < STEPS_PER_OCTAVE; k++) pow2_q24[k] = exp_neg_q24(k);
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_config_cases();
    test_random(280, 0, 0);
    write_reg(CFG_MASTER_CLOCK, 26'h3ffffff);
    write_reg(CFG_REF_PITCH, 26'd400000);
    test_random(230, 53, 0);
    write_reg(CFG_MASTER_CLOCK, 26'd1);
    write_reg(CFG_REF_PITCH, 26'd480000);
    test_random(120, 0, 53);
    write_reg(CFG_MASTER_CLOCK, 26'd3579545);
    write_reg(CFG_REF_PITCH, 26'($urandom_range(400000, 480000)));
    test_random(230, 20, 20);
    test_backpressure();
    write_reg(CFG_MASTER_CLOCK, 26'($urandom));
    write_reg(CFG_REF_PITCH, 26'($urandom_range(400000, 480000)));
    test_random(280, 20, 20);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait (divider_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fails == 0) $display("tb_pitch_to_divider_octave_core OK");
    else $display("tb_pitch_to_divider_octave_core NOT OK");
    $finish;
  end

endmodule

### filelist.f
design/ptd_pkg.sv
design/ptd_div_cell.sv
design/ptd_out_skid.sv
design/pitch_to_divider_octave_core.sv
tb/sv/tb_pitch_to_divider_octave_core.sv
